[src/ksdt_pkg.sv]
package ksdt_pkg;

    localparam int DEPTH_DEFAULT = 4;
    localparam int VALUE_W       = 32;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [1:0] {
        ST_APPEND  = 2'd0,
        ST_DISCARD = 2'd1,
        ST_DUP     = 2'd2,
        ST_REPLACE = 2'd3
    } t_status;

    // One word as the front hands it to the back.
    typedef struct packed {
        logic               append;
        logic [VALUE_W-1:0] value;
    } t_qword;

    typedef struct packed {
        logic   valid;
        t_qword word;
    } t_qchan;

endpackage

[src/ksdt_in_if.sv]
interface ksdt_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [ksdt_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

[src/ksdt_out_if.sv]
interface ksdt_out_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          status;
    logic signed [ksdt_pkg::VALUE_W-1:0] evicted_value;

    modport source (output valid, output status, output evicted_value, input ready);
    modport sink   (input valid, input status, input evicted_value, output ready);
endinterface

[src/ksdt_front.sv]
module ksdt_front #(
    parameter int DEPTH = ksdt_pkg::DEPTH_DEFAULT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ksdt_in_if.sink         i_in,
    output ksdt_pkg::t_qchan o_push,
    input  logic            i_push_ready
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          filling;

    // The first DEPTH words always append; every later word needs a scan.
    assign filling = (r_cnt != CW'(DEPTH));

    assign o_push.valid       = i_in.valid;
    assign o_push.word.append = filling;
    assign o_push.word.value  = i_in.value;
    assign i_in.ready         = i_push_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (i_in.valid && i_push_ready && filling) begin
            n_cnt = r_cnt + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

[src/ksdt_queue.sv]
module ksdt_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ksdt_pkg::t_qchan i_push,
    output logic             o_push_ready,
    output ksdt_pkg::t_qchan o_pop,
    input  logic             i_pop_ready
);

    localparam int PW = $clog2(ksdt_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(ksdt_pkg::QUEUE_DEPTH + 1);

    ksdt_pkg::t_qword r_slot [ksdt_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [PW-1:0]    n_wr_ptr;
    logic [PW-1:0]    n_rd_ptr;
    logic [CW-1:0]    n_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CW'(ksdt_pkg::QUEUE_DEPTH));
    assign o_pop.valid  = (r_count != '0);
    assign o_pop.word   = r_slot[r_rd_ptr];

    assign push = i_push.valid && o_push_ready;
    assign pop  = o_pop.valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + PW'(1) : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + PW'(1) : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + CW'(1);
        end else if (pop && !push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push.word;
        end
    end

endmodule

[src/ksdt_back.sv]
module ksdt_back #(
    parameter int DEPTH = ksdt_pkg::DEPTH_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ksdt_pkg::t_qchan i_q,
    output logic             o_q_ready,
    ksdt_out_if.source       o_out
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VW = ksdt_pkg::VALUE_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DEC  = 3'b100
    } t_state;

    logic [VW-1:0]     mem [DEPTH];
    logic [VW-1:0]     r_rd_data;

    t_state            r_state,    n_state;
    logic [IW-1:0]     r_wr_idx,   n_wr_idx;
    logic [IW-1:0]     r_rd_idx,   n_rd_idx;
    logic [IW-1:0]     r_cmp_idx,  n_cmp_idx;
    logic              r_out_valid, n_out_valid;
    logic signed [VW-1:0] r_val,   n_val;
    logic signed [VW-1:0] r_max,   n_max;
    logic [IW-1:0]     r_maxi,     n_maxi;
    logic              r_dup,      n_dup;
    ksdt_pkg::t_status r_status,   n_status;
    logic signed [VW-1:0] r_evicted, n_evicted;

    logic              out_free;
    logic              pop;
    logic              scan_last;
    logic              replace;
    logic [IW-1:0]     rd_addr;
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    logic [VW-1:0]     mem_wdata;

    assign out_free  = !r_out_valid || o_out.ready;
    assign pop       = (r_state == S_IDLE) && i_q.valid && out_free;
    assign o_q_ready = pop;
    assign scan_last = (r_cmp_idx == IW'(DEPTH - 1));
    assign replace   = !(r_val > r_max) && !r_dup;
    assign rd_addr   = (r_state == S_IDLE) ? '0 : r_rd_idx;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_wr_idx;
        mem_wdata = i_q.word.value;
        if (pop && i_q.word.append) begin
            mem_we = 1'b1;
        end else if (r_state == S_DEC && replace) begin
            mem_we    = 1'b1;
            mem_waddr = r_maxi;
            mem_wdata = r_val;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_wr_idx    = r_wr_idx;
        n_rd_idx    = r_rd_idx;
        n_cmp_idx   = r_cmp_idx;
        n_out_valid = r_out_valid && !o_out.ready;
        n_val       = r_val;
        n_max       = r_max;
        n_maxi      = r_maxi;
        n_dup       = r_dup;
        n_status    = r_status;
        n_evicted   = r_evicted;
        case (r_state)
            S_IDLE: begin
                if (pop) begin
                    if (i_q.word.append) begin
                        n_wr_idx    = r_wr_idx + IW'(1);
                        n_out_valid = 1'b1;
                        n_status    = ksdt_pkg::ST_APPEND;
                        n_evicted   = '0;
                    end else begin
                        // Entry 0 is already being read this cycle.
                        n_val     = i_q.word.value;
                        n_rd_idx  = IW'(1);
                        n_cmp_idx = '0;
                        n_state   = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Strict compare keeps the lowest index among tied maxima.
                if (r_cmp_idx == '0 || $signed(r_rd_data) > r_max) begin
                    n_max  = r_rd_data;
                    n_maxi = r_cmp_idx;
                end
                n_dup     = ((r_cmp_idx == '0) ? 1'b0 : r_dup) || (r_rd_data == r_val);
                n_rd_idx  = r_rd_idx + IW'(1);
                n_cmp_idx = r_cmp_idx + IW'(1);
                if (scan_last) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_out_valid = 1'b1;
                n_evicted   = '0;
                if (r_val > r_max) begin
                    n_status = ksdt_pkg::ST_DISCARD;
                end else if (r_dup) begin
                    n_status = ksdt_pkg::ST_DUP;
                end else begin
                    n_status  = ksdt_pkg::ST_REPLACE;
                    n_evicted = r_max;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_cmp_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_idx    <= n_wr_idx;
            r_rd_idx    <= n_rd_idx;
            r_cmp_idx   <= n_cmp_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val     <= n_val;
        r_max     <= n_max;
        r_maxi    <= n_maxi;
        r_dup     <= n_dup;
        r_status  <= n_status;
        r_evicted <= n_evicted;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[rd_addr];
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_status;
    assign o_out.evicted_value = r_evicted;

    a_pop_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> out_free)
        else $error("word popped while result slot busy");

    a_dec_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC) |=> (r_out_valid && r_state == S_IDLE))
        else $error("decision did not produce a result");

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && scan_last) |=> (r_state == S_DEC))
        else $error("scan ran past last entry");

    a_scan_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_SCAN) |-> ($past(pop) && r_cmp_idx == '0))
        else $error("scan started without a popped word");

endmodule

[src/k_smallest_distinct_tracker.sv]
// A word passes the queue slot and result register; once the store is
// full it also passes the scan (one store entry per cycle, single read
// port) and the decision state. One word per cycle while filling, unless
// the output stalls; once full, the next word waits for the decision.
// A 2-word queue keeps accepting while a result waits on the output.
// Reset (synchronous, active low) empties the store and the queue.
module k_smallest_distinct_tracker #(
    parameter int DEPTH = ksdt_pkg::DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ksdt_in_if.sink     i_in,
    ksdt_out_if.source  o_out
);

    ksdt_pkg::t_qchan push;
    ksdt_pkg::t_qchan pop;
    logic             push_ready;
    logic             pop_ready;

    ksdt_front #(.DEPTH(DEPTH)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push       (push),
        .i_push_ready (push_ready)
    );

    ksdt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .o_pop        (pop),
        .i_pop_ready  (pop_ready)
    );

    ksdt_back #(.DEPTH(DEPTH)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q       (pop),
        .o_q_ready (pop_ready),
        .o_out     (o_out)
    );

endmodule
